@@ sv/ssas_pkg.sv @@
// Shared types and constants for the stream substring / set search block.
// No dependencies.
`default_nettype none

package ssas_pkg;

   // Search modes held in the mode register
   typedef enum logic [1:0] {
      MODE_SUBSTR  = 2'd0,
      MODE_ANY_OF  = 2'd1,
      MODE_NONE_OF = 2'd2
   } search_mode_type;

   // CSR register indexes
   localparam logic [2:0] CSR_SEARCH_MODE   = 3'd0;
   localparam logic [2:0] CSR_PATTERN_LEN   = 3'd1;
   localparam logic [2:0] CSR_PATTERN_LOW   = 3'd2;
   localparam logic [2:0] CSR_PATTERN_HIGH  = 3'd3;
   localparam logic [2:0] CSR_START_POS     = 3'd4;

   localparam int CSR_DATA_BITS  = 64;
   localparam int PAT_SLOT_BITS  = 16;
   localparam int TEXT_BITS      = 16;
   localparam int POS_BITS       = 16;
   localparam int LEN_BITS       = 4;

   // Per-beat control handed from the top level to every cell
   typedef struct packed {
      logic update;   // a text beat is accepted this cycle
      logic clear;    // drop the prefix bit (below start or end of text)
      logic advance;  // substring mode: shift the prefix chain
   } cell_ctl_type;

endpackage

`default_nettype wire

@@ sv/ssas_cell.sv @@
// One cell of the prefix-match chain: compares the text character with one
// pattern character and holds the prefix-match bit for that position.
// Depends on ssas_pkg.
`default_nettype none

module ssas_cell (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire ssas_pkg::cell_ctl_type             ctl,
   input  wire logic [ssas_pkg::TEXT_BITS-1:0]     text_char,
   input  wire logic [ssas_pkg::TEXT_BITS-1:0]     pat_char,
   input  wire logic                               in_use,
   input  wire logic                               prev_match,
   output logic                                    char_eq,
   output logic                                    match_next,
   output logic                                    match_q
);

   logic match_ff;
   logic match_in;

   assign char_eq    = in_use && (text_char == pat_char);
   assign match_next = prev_match && char_eq;
   assign match_q    = match_ff;

   always_comb begin
      match_in = match_ff;
      if (ctl.update) begin
         if (ctl.clear) begin
            match_in = 1'b0;
         end else if (ctl.advance) begin
            match_in = match_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/stream_substring_and_set_search.sv @@
// Streaming substring / character-set search, top level.
// Depends on ssas_pkg and ssas_cell.
//
// Usage:
//   Text enters on the req_ channel, one 16-bit character per beat, with
//   req_final_char set on the last character. CSRs (mode, pattern length,
//   pattern characters, start position) are written through csr_write /
//   csr_index / csr_wdata while no text is in flight.
//   At most one beat per text leaves on rsp_: the first hit (rsp_found = 1,
//   rsp_hit_position = index of the hit, for substring mode the index of the
//   first matched character), or, if no hit by the last character, a
//   not-found beat (rsp_found = 0, position 0) with that last character.
//   Throughput: one character per cycle. Latency: the result beat is valid
//   the cycle after the character that causes it is accepted. The pattern
//   is checked by a row of MAX_PATTERN cells, one per pattern position, each
//   passing its prefix-match bit to its neighbor every substring-mode beat.
//   A single output register holds the result; while it is stalled by
//   rsp_ready low, req_ready drops, and it rises again in the cycle the
//   held beat is taken.
//   Reset (synchronous) clears CSRs to zero, the character index, the
//   prefix bits and the hit flag; no clearing pass is needed.
`default_nettype none

module stream_substring_and_set_search #(
   parameter int MAX_PATTERN = 8,
   parameter int MAX_TEXT    = 65536,
   parameter int CHAR_BITS   = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic [ssas_pkg::TEXT_BITS-1:0]         req_text_char,
   input  wire logic                                   req_final_char,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic                                        rsp_found,
   output logic [ssas_pkg::POS_BITS-1:0]               rsp_hit_position,
   input  wire logic                                   csr_write,
   input  wire logic [2:0]                             csr_index,
   input  wire logic [ssas_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int IDX_BITS = $clog2(MAX_TEXT);
   localparam int CMP_BITS = (CHAR_BITS < ssas_pkg::TEXT_BITS) ? CHAR_BITS
                                                               : ssas_pkg::TEXT_BITS;
   localparam logic [ssas_pkg::TEXT_BITS-1:0] CHAR_MASK =
      ssas_pkg::TEXT_BITS'((64'd1 << CMP_BITS) - 64'd1);
   localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(MAX_TEXT - 1);
   localparam logic signed [18:0] TEXT_MOD = 19'(MAX_TEXT);
   // 2^32 mod MAX_TEXT: a 32-bit unsigned underflow of the hit position
   localparam logic signed [18:0] WRAP_REM = 19'((64'd1 << 32) % MAX_TEXT);

   // CSRs
   logic [1:0]                               mode_ff;
   logic [ssas_pkg::LEN_BITS-1:0]            len_ff;
   logic [ssas_pkg::CSR_DATA_BITS-1:0]       pat_lo_ff;
   logic [ssas_pkg::CSR_DATA_BITS-1:0]       pat_hi_ff;
   logic [ssas_pkg::POS_BITS-1:0]            start_ff;

   // Text state
   logic [IDX_BITS-1:0]                      idx_ff;
   logic [IDX_BITS-1:0]                      idx_in;
   logic                                     hit_reported_ff;
   logic                                     hit_reported_in;

   // Output register
   logic                                     rsp_valid_ff;
   logic                                     rsp_valid_in;
   logic                                     rsp_found_ff;
   logic                                     rsp_found_in;
   logic [ssas_pkg::POS_BITS-1:0]            rsp_pos_ff;
   logic [ssas_pkg::POS_BITS-1:0]            rsp_pos_in;

   logic                                     req_fire;
   logic [ssas_pkg::TEXT_BITS-1:0]           text_masked;
   logic [ssas_pkg::LEN_BITS-1:0]            n_eff;
   logic [ssas_pkg::LEN_BITS-1:0]            n_m1;
   logic                                     qualified;
   logic                                     substr_hit;
   logic                                     hit;
   logic                                     emit;
   logic [ssas_pkg::POS_BITS-1:0]            hit_pos;
   logic [2*ssas_pkg::CSR_DATA_BITS-1:0]     pat_all;
   ssas_pkg::search_mode_type                mode;
   ssas_pkg::cell_ctl_type                   cell_ctl;

   logic [MAX_PATTERN-1:0]                   eq_vec;
   logic [MAX_PATTERN-1:0]                   match_next_vec;
   logic [MAX_PATTERN-1:0]                   match_vec;
   logic [MAX_PATTERN-1:0]                   used_vec;
   logic [MAX_PATTERN-1:0]                   tail_vec;

   assign req_fire    = req_valid && req_ready;
   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign text_masked = req_text_char & CHAR_MASK;
   assign pat_all     = {pat_hi_ff, pat_lo_ff};
   assign mode        = ssas_pkg::search_mode_type'(mode_ff);

   assign n_eff = (len_ff > ssas_pkg::LEN_BITS'(MAX_PATTERN)) ?
                  ssas_pkg::LEN_BITS'(MAX_PATTERN) : len_ff;
   assign n_m1  = n_eff - ssas_pkg::LEN_BITS'(1);

   assign qualified = ssas_pkg::POS_BITS'(idx_ff) >= start_ff;

   assign cell_ctl.update  = req_fire;
   assign cell_ctl.clear   = req_final_char || !qualified;
   assign cell_ctl.advance = (mode == ssas_pkg::MODE_SUBSTR);

   // Row of cells; cell k sees the prefix bit of cell k-1 from the last beat
   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      logic prev_bit;

      assign used_vec[k] = ssas_pkg::LEN_BITS'(k) < n_eff;
      assign tail_vec[k] = ssas_pkg::LEN_BITS'(k + 1) == n_eff;

      if (k == 0) begin : g_head
         assign prev_bit = 1'b1;
      end else begin : g_link
         assign prev_bit = match_vec[k-1];
      end

      ssas_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl),
         .text_char  (text_masked),
         .pat_char   (pat_all[k*ssas_pkg::PAT_SLOT_BITS +: ssas_pkg::PAT_SLOT_BITS]
                      & CHAR_MASK),
         .in_use     (used_vec[k]),
         .prev_match (prev_bit),
         .char_eq    (eq_vec[k]),
         .match_next (match_next_vec[k]),
         .match_q    (match_vec[k])
      );
   end

   assign substr_hit = |(match_next_vec & tail_vec);

   always_comb begin
      hit = 1'b0;
      if (qualified) begin
         unique case (mode)
            ssas_pkg::MODE_SUBSTR:  hit = substr_hit;
            ssas_pkg::MODE_ANY_OF:  hit = |eq_vec;
            ssas_pkg::MODE_NONE_OF: hit = ~|eq_vec;
            default:                hit = 1'b0;
         endcase
      end
   end

   // Hit position: substring start is index - (n-1), modulo the text size
   always_comb begin
      logic signed [18:0] diff;
      logic signed [18:0] v;
      diff = 19'(idx_ff) + TEXT_MOD - 19'(n_m1);
      v    = (diff < 0) ? (WRAP_REM + diff) : diff;
      for (int i = 0; i < 4; i++) begin
         if (v < 0) begin
            v = v + TEXT_MOD;
         end
      end
      if (v >= TEXT_MOD) begin
         v = v - TEXT_MOD;
      end
      if (mode == ssas_pkg::MODE_SUBSTR) begin
         hit_pos = v[ssas_pkg::POS_BITS-1:0];
      end else begin
         hit_pos = ssas_pkg::POS_BITS'(idx_ff);
      end
   end

   assign emit = req_fire && !hit_reported_ff && (hit || req_final_char);

   always_comb begin
      idx_in          = idx_ff;
      hit_reported_in = hit_reported_ff;
      if (req_fire) begin
         if (req_final_char) begin
            idx_in          = '0;
            hit_reported_in = 1'b0;
         end else begin
            idx_in = (idx_ff == IDX_LAST) ? '0 : idx_ff + IDX_BITS'(1);
            if (emit && hit) begin
               hit_reported_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = hit;
         rsp_pos_in   = hit ? hit_pos : '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff          <= '0;
         hit_reported_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         idx_ff          <= idx_in;
         hit_reported_ff <= hit_reported_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= '0;
         len_ff    <= '0;
         pat_lo_ff <= '0;
         pat_hi_ff <= '0;
         start_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            ssas_pkg::CSR_SEARCH_MODE:  mode_ff   <= csr_wdata[1:0];
            ssas_pkg::CSR_PATTERN_LEN:  len_ff    <= csr_wdata[ssas_pkg::LEN_BITS-1:0];
            ssas_pkg::CSR_PATTERN_LOW:  pat_lo_ff <= csr_wdata;
            ssas_pkg::CSR_PATTERN_HIGH: pat_hi_ff <= csr_wdata;
            ssas_pkg::CSR_START_POS:    start_ff  <= csr_wdata[ssas_pkg::POS_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_hit_position = rsp_pos_ff;

`ifndef NO_ASSERTIONS
   // End of text returns the per-text state to zero
   a_text_end_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_final_char |=> (idx_ff == '0) && !hit_reported_ff && (match_vec == '0))
      else $error("per-text state not cleared after final beat");

   // Once a hit is out, no further beat is produced for this text
   a_single_report: assert property (@(posedge clock) disable iff (reset)
      req_fire && hit_reported_ff |-> !emit)
      else $error("second result beat for one text");

   // Characters before the start position leave no prefix bits behind
   a_below_start_clear: assert property (@(posedge clock) disable iff (reset)
      req_fire && !qualified |=> (match_vec == '0))
      else $error("prefix bits set below start position");

   // Input is only throttled by a held result beat
   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid_ff && !rsp_ready)
      else $error("req_ready low without stalled result");
`endif

endmodule

`default_nettype wire
